>>> hdl/oerf_pkg.sv
package oerf_pkg;

  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int OFFSET_W = 20;
  localparam int SLOT_OUT_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_FIND
  } state_t;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_FIND = 1'b1
  } mode_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } record_t;

endpackage

>>> hdl/oerf_store.sv
module oerf_store #(
  parameter int ENTRIES = 16,
  parameter int SLOT_W  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SLOT_W-1:0]    rd_addr,
  output oerf_pkg::record_t    rd_rec,
  input  logic                 wr_en,
  input  logic [SLOT_W-1:0]    wr_addr,
  input  oerf_pkg::record_t    wr_rec
);

  oerf_pkg::record_t mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  oerf_pkg::record_t rd_data;
  logic rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_data <= mem[rd_addr];
  end

  // never-written entries read as the cleared record
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  assign rd_rec = rd_written ? rd_data : '0;

endmodule

>>> hdl/overwriting_entry_ring_with_offset_find.sv
// add: record read at accept, then rewritten and result registered in ST_ADD once the output is free
// find: walks stored sizes from the oldest slot, one memory read per cycle; the result is
// registered once a slot holds the offset or all ENTRIES slots are visited, and the output is free
// one transaction at a time; the next input is taken the cycle after the result is registered,
// and the result waits while the output register is still held
// reset clears slot pointers, full flag and per-entry written bits, so all records read as zero
module overwriting_entry_ring_with_offset_find #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // new_size[15:0], new_handle[47:16], byte_offset[67:48], zero
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // found[0], slot_index[4:1], offset_in_record[20:5],
                                // record_size[36:21], result_handle[68:37], overwrote[69], zero
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int POS_W  = oerf_pkg::SIZE_W + SLOT_W;
  localparam int CMP_W  = (POS_W > oerf_pkg::OFFSET_W) ? POS_W : oerf_pkg::OFFSET_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  oerf_pkg::state_t state, state_next;

  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [SLOT_W-1:0] read_slot, read_slot_next;
  logic              ring_full, ring_full_next;
  logic [SLOT_W-1:0] cur, cur_next;
  logic [SLOT_W-1:0] cnt, cnt_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [oerf_pkg::OFFSET_W-1:0] off, off_next;
  oerf_pkg::record_t new_rec, new_rec_next;

  logic [SLOT_W-1:0] rd_addr;
  oerf_pkg::record_t rd_rec;
  logic              wr_en;

  logic [oerf_pkg::SIZE_W-1:0]   new_size;
  logic [oerf_pkg::HANDLE_W-1:0] new_handle;
  logic [oerf_pkg::OFFSET_W-1:0] byte_offset;
  logic                          in_take;
  logic                          out_free;

  logic [POS_W-1:0] pos_end;
  logic             hit;
  logic [SLOT_W-1:0] cur_inc;
  logic [SLOT_W-1:0] wr_inc;

  logic                              found, found_next;
  logic [oerf_pkg::SLOT_OUT_W-1:0]   slot_index, slot_index_next;
  logic [oerf_pkg::SIZE_W-1:0]       offset_in_record, offset_in_record_next;
  logic [oerf_pkg::SIZE_W-1:0]       record_size, record_size_next;
  logic [oerf_pkg::HANDLE_W-1:0]     result_handle, result_handle_next;
  logic                              overwrote, overwrote_next;
  logic                              out_load;

  assign new_size    = s_tdata[15:0];
  assign new_handle  = s_tdata[47:16];
  assign byte_offset = s_tdata[67:48];

  assign s_tready = (state == oerf_pkg::ST_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign cur_inc = (cur == LAST_SLOT) ? '0 : cur + 1'b1;
  assign wr_inc  = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign pos_end = pos + POS_W'(rd_rec.size);
  assign hit     = CMP_W'(off) < CMP_W'(pos_end);

  oerf_store #(
    .ENTRIES (ENTRIES),
    .SLOT_W  (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (write_slot),
    .wr_rec  (new_rec)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      oerf_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = (oerf_pkg::mode_t'(s_tuser) == oerf_pkg::MODE_FIND) ?
                       oerf_pkg::ST_FIND : oerf_pkg::ST_ADD;
        end
      end
      oerf_pkg::ST_ADD: begin
        if (out_free) begin
          state_next = oerf_pkg::ST_IDLE;
        end
      end
      oerf_pkg::ST_FIND: begin
        if ((hit || cnt == LAST_SLOT) && out_free) begin
          state_next = oerf_pkg::ST_IDLE;
        end
      end
      default: state_next = oerf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    write_slot_next       = write_slot;
    read_slot_next        = read_slot;
    ring_full_next        = ring_full;
    cur_next              = cur;
    cnt_next              = cnt;
    pos_next              = pos;
    off_next              = off;
    new_rec_next          = new_rec;
    rd_addr               = cur;
    wr_en                 = 1'b0;
    out_load              = 1'b0;
    found_next            = 1'b0;
    slot_index_next       = '0;
    offset_in_record_next = '0;
    record_size_next      = '0;
    result_handle_next    = '0;
    overwrote_next        = 1'b0;
    case (state)
      oerf_pkg::ST_IDLE: begin
        if (in_take) begin
          if (oerf_pkg::mode_t'(s_tuser) == oerf_pkg::MODE_FIND) begin
            cur_next = read_slot;
          end else begin
            cur_next = write_slot;
          end
          rd_addr             = cur_next;
          cnt_next            = '0;
          pos_next            = '0;
          off_next            = byte_offset;
          new_rec_next.size   = new_size;
          new_rec_next.handle = new_handle;
        end
      end
      oerf_pkg::ST_ADD: begin
        if (out_free) begin
          wr_en           = 1'b1;
          out_load        = 1'b1;
          write_slot_next = wr_inc;
          if (ring_full) begin
            result_handle_next = rd_rec.handle;
            overwrote_next     = 1'b1;
            read_slot_next     = wr_inc;
          end
          if (wr_inc == read_slot_next) begin
            ring_full_next = 1'b1;
          end
        end
      end
      oerf_pkg::ST_FIND: begin
        if (hit) begin
          if (out_free) begin
            out_load              = 1'b1;
            found_next            = 1'b1;
            slot_index_next       = oerf_pkg::SLOT_OUT_W'(cur);
            offset_in_record_next = oerf_pkg::SIZE_W'(CMP_W'(off) - CMP_W'(pos));
            record_size_next      = rd_rec.size;
            result_handle_next    = rd_rec.handle;
          end
        end else if (cnt == LAST_SLOT) begin
          // offset at or past the stored total
          out_load = out_free;
        end else begin
          pos_next = pos_end;
          cnt_next = cnt + 1'b1;
          cur_next = cur_inc;
          rd_addr  = cur_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= oerf_pkg::ST_IDLE;
      write_slot <= '0;
      read_slot  <= '0;
      ring_full  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      write_slot <= write_slot_next;
      read_slot  <= read_slot_next;
      ring_full  <= ring_full_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    cnt     <= cnt_next;
    pos     <= pos_next;
    off     <= off_next;
    new_rec <= new_rec_next;
    if (out_load) begin
      found            <= found_next;
      slot_index       <= slot_index_next;
      offset_in_record <= offset_in_record_next;
      record_size      <= record_size_next;
      result_handle    <= result_handle_next;
      overwrote        <= overwrote_next;
    end
  end

  assign m_tdata = {2'b00, overwrote, result_handle, record_size, offset_in_record,
                    slot_index, found};

endmodule

>>> verif/record_ring_checker.sv
module record_ring_checker #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic                            found;
    logic [oerf_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [oerf_pkg::SIZE_W-1:0]     offset_in_record;
    logic [oerf_pkg::SIZE_W-1:0]     record_size;
    logic [oerf_pkg::HANDLE_W-1:0]   result_handle;
    logic                            overwrote;
  } ring_result_t;

  logic [oerf_pkg::SIZE_W-1:0]   sizes   [ENTRIES];
  logic [oerf_pkg::HANDLE_W-1:0] handles [ENTRIES];
  int                  wr_slot;
  int                  rd_slot;
  logic                ring_full;
  ring_result_t        expected_results[$];
  int                  mismatch_count = 0;

  assign mismatches = mismatch_count;

  function automatic int next_slot(int s);
    return (s + 1 >= ENTRIES) ? 0 : s + 1;
  endfunction

  // advances the ring copy by one transaction and returns what the block should answer
  function automatic ring_result_t apply_ring_op(oerf_pkg::mode_t mode,
                                                 logic [oerf_pkg::SIZE_W-1:0] size,
                                                 logic [oerf_pkg::HANDLE_W-1:0] handle,
                                                 logic [oerf_pkg::OFFSET_W-1:0] offset);
    ring_result_t res;
    int           slot;
    int unsigned  pos;
    res = '0;
    if (mode == oerf_pkg::MODE_ADD) begin
      if (ring_full) begin
        res.result_handle = handles[wr_slot];
        res.overwrote     = 1'b1;
      end
      sizes[wr_slot]   = size;
      handles[wr_slot] = handle;
      wr_slot          = next_slot(wr_slot);
      if (ring_full) rd_slot = wr_slot;
      if (wr_slot == rd_slot) ring_full = 1'b1;
    end else begin
      slot = rd_slot;
      pos  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        // zero-length records never satisfy this, so they are passed over
        if (32'(offset) < pos + 32'(sizes[slot])) begin
          res.found            = 1'b1;
          res.slot_index       = oerf_pkg::SLOT_OUT_W'(slot);
          res.offset_in_record = oerf_pkg::SIZE_W'(32'(offset) - pos);
          res.record_size      = sizes[slot];
          res.result_handle    = handles[slot];
          return res;
        end
        pos  = pos + 32'(sizes[slot]);
        slot = next_slot(slot);
      end
    end
    return res;
  endfunction

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        sizes[i]   = '0;
        handles[i] = '0;
      end
      wr_slot   = 0;
      rd_slot   = 0;
      ring_full = 1'b0;
      expected_results.delete();
    end else begin
      // the block works one transaction at a time, so a result always belongs to an older input
      if (m_tvalid && m_tready) begin
        got.found            = m_tdata[0];
        got.slot_index       = m_tdata[4:1];
        got.offset_in_record = m_tdata[20:5];
        got.record_size      = m_tdata[36:21];
        got.result_handle    = m_tdata[68:37];
        got.overwrote        = m_tdata[69];
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: tdata 0x%0h", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("found", 64'(want.found), 64'(got.found));
          compare_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
          compare_field("offset_in_record", 64'(want.offset_in_record),
                        64'(got.offset_in_record));
          compare_field("record_size", 64'(want.record_size), 64'(got.record_size));
          compare_field("result_handle", 64'(want.result_handle), 64'(got.result_handle));
          compare_field("overwrote", 64'(want.overwrote), 64'(got.overwrote));
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_ring_op(oerf_pkg::mode_t'(s_tuser), s_tdata[15:0],
                                                 s_tdata[47:16], s_tdata[67:48]));
    end
    outstanding <= expected_results.size();
  end

endmodule

>>> verif/tb_overwriting_entry_ring_with_offset_find.sv
module tb_overwriting_entry_ring_with_offset_find;

  localparam int RING_ENTRIES = 16;
  localparam int RANDOM_ITEMS = 750;
  localparam int LONG_HOLD    = 300;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;  // new_size, new_handle, byte_offset, zero
  logic        s_tuser  = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // found, slot_index, offset_in_record, record_size,
                               // result_handle, overwrote, zero
  int          mismatches;
  int          outstanding;

  always #5 clk = ~clk;

  overwriting_entry_ring_with_offset_find #(
    .ENTRIES(RING_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  record_ring_checker #(
    .ENTRIES(RING_ENTRIES)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // offers one transaction and returns at the edge where it is taken
  task automatic offer_item(oerf_pkg::mode_t mode, logic [oerf_pkg::SIZE_W-1:0] size,
                            logic [oerf_pkg::HANDLE_W-1:0] handle,
                            logic [oerf_pkg::OFFSET_W-1:0] offset);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, offset, handle, size};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic offer_random_item();
    logic [oerf_pkg::SIZE_W-1:0]   size;
    logic [oerf_pkg::OFFSET_W-1:0] offset;
    int                            pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 55) begin
      if (pick < 10) size = '0;
      else if (pick < 18) size = oerf_pkg::SIZE_W'($urandom);
      else if (pick < 24) size = '1;
      else size = oerf_pkg::SIZE_W'($urandom_range(1, 200));
      offer_item(oerf_pkg::MODE_ADD, size, $urandom, oerf_pkg::OFFSET_W'($urandom));
    end else begin
      if (pick < 8) offset = '0;
      else if (pick < 22) offset = oerf_pkg::OFFSET_W'($urandom);
      else if (pick < 28) offset = '1;
      else offset = oerf_pkg::OFFSET_W'($urandom_range(0, 3500));
      offer_item(oerf_pkg::MODE_FIND, oerf_pkg::SIZE_W'($urandom), $urandom, offset);
    end
  endtask

  // lets the checker catch up with the last accepted transaction first
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int burst;
    int gap;
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty ring, zero-length leading record, largest record, then fill and overwrite
    offer_item(oerf_pkg::MODE_FIND, '0, '0, '0);
    offer_item(oerf_pkg::MODE_FIND, '1, '1, '1);
    offer_item(oerf_pkg::MODE_ADD, '0, 32'hA5A5_0001, '0);
    offer_item(oerf_pkg::MODE_ADD, 16'd3, '1, '1);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd0);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd2);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd3);
    offer_item(oerf_pkg::MODE_ADD, '1, '0, '0);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd3);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd65537);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd65538);
    for (int i = 0; i < RING_ENTRIES - 3; i++)
      offer_item(oerf_pkg::MODE_ADD, '1, 32'h1000_0000 + i, '0);
    offer_item(oerf_pkg::MODE_ADD, '1, 32'h2000_0000, '0);
    offer_item(oerf_pkg::MODE_ADD, '1, 32'h2000_0001, '0);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, '1);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd1048559);
    offer_item(oerf_pkg::MODE_FIND, '0, '0, 20'd0);
    s_tvalid <= 1'b0;
    wait_drained();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
        if (n == RANDOM_ITEMS / 2) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
        offer_random_item();
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stall pattern, with two long hold-offs so the block backs up its input
  initial begin
    int cycle_cnt;
    int next_hold;
    int holds_done;
    int style;
    int run;
    cycle_cnt  = 0;
    holds_done = 0;
    next_hold  = $urandom_range(1500, 2500);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < 2 && cycle_cnt >= next_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        cycle_cnt += LONG_HOLD;
        holds_done++;
        next_hold = cycle_cnt + $urandom_range(8000, 10000);
      end else begin
        style = $urandom_range(0, 2);
        run   = $urandom_range(1, 40);
        for (int i = 0; i < run; i++) begin
          case (style)
            0: begin
              m_tready <= 1'b1;
            end
            1: begin
              m_tready <= (i % 5 == 4);
            end
            default: begin
              m_tready <= 1'($urandom);
            end
          endcase
          @(posedge clk);
          cycle_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
hdl/oerf_pkg.sv
hdl/oerf_store.sv
hdl/overwriting_entry_ring_with_offset_find.sv
verif/record_ring_checker.sv
verif/tb_overwriting_entry_ring_with_offset_find.sv
